[sv/p2oc_pkg.sv]
// Shared constants, register codes and the divider beat type for the pixel to
// occupancy cell pipeline. No dependencies.
package p2oc_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int NUM_CH = 4;
  localparam int CHAN_W = 8;
  localparam int CNT_W  = 3;
  localparam int SUM_W  = 10;   // up to 4 * 255
  localparam int THR_W  = 16;   // Q0.16 thresholds
  localparam int PROD_W = 26;   // threshold * 255 * count, and occupancy << 16
  localparam int QUOT_W = 7;    // scaled result never exceeds 99
  localparam int NUM_W  = 33;   // 99 * (occupancy - free) in the same scale

  localparam logic [CHAN_W-1:0] CELL_OCCUPIED = 8'd100;
  localparam logic [CHAN_W-1:0] CELL_FREE     = 8'd0;
  localparam logic [CHAN_W-1:0] CELL_UNKNOWN  = 8'd255;
  localparam logic [CHAN_W-1:0] CHAN_FULL     = 8'd255;
  localparam logic [CHAN_W-1:0] SCALE_TOP     = 8'd99;

  localparam logic [1:0] MODE_TRINARY = 2'd0;
  localparam logic [1:0] MODE_SCALE   = 2'd1;
  localparam logic [1:0] MODE_RAW     = 2'd2;

  localparam logic [THR_W-1:0] OCC_THR_RST  = 16'd42598;
  localparam logic [THR_W-1:0] FREE_THR_RST = 16'd12845;
  localparam logic [CNT_W-1:0] CHAN_CNT_RST = 3'd1;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_NEGATE    = 3'd1,
    REG_OCC_THR   = 3'd2,
    REG_FREE_THR  = 3'd3,
    REG_CHAN_CNT  = 3'd4,
    REG_ALPHA     = 3'd5,
    REG_MAP_WIDTH = 3'd6,
    REG_MAP_HEIGHT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [PROD_W-1:0] den;
    logic [QUOT_W-1:0] quot;
    logic [CHAN_W-1:0] fixed;
    logic              use_quot;
  } div_t;

endpackage

[sv/pixel_to_occupancy_cell.sv]
// Top level: pixel to occupancy grid cell converter, configuration registers
// and a 13-stage pipeline. Depends on p2oc_pkg and p2oc_div_stage.
//
//   channel   handshake                 payload
//   in        in_valid_i / in_stall_o   column_i row_i chan0_i..chan3_i
//   out       out_valid_o / out_stall_i cell_value_o cell_index_o
//   cfg       cfg_we_i                  cfg_idx_i cfg_data_i
//
// Throughput is one pixel per clock while the output is not stalled; the stages are one
// capture stage, four arithmetic stages, seven divider stages and one output register.
// The seven divider stages each resolve one quotient bit of the scale-mode
// ratio, which never exceeds 99.
// Reset clears all valid bits and loads the configuration defaults.
// Each stage holds its beat only while the stage after it is full and
// blocked, so bubbles collapse and a stall at the output backs up stage by
// stage without loss or duplication.
module pixel_to_occupancy_cell #(
  parameter int COORD_BITS = p2oc_pkg::COORD_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [2:0]                                   cfg_idx_i,
  input  logic [((COORD_BITS + 1 > p2oc_pkg::THR_W) ?
                 COORD_BITS + 1 : p2oc_pkg::THR_W)-1:0] cfg_data_i,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  logic [COORD_BITS-1:0]                        column_i,
  input  logic [COORD_BITS-1:0]                        row_i,
  input  logic [p2oc_pkg::CHAN_W-1:0]                  chan0_i,
  input  logic [p2oc_pkg::CHAN_W-1:0]                  chan1_i,
  input  logic [p2oc_pkg::CHAN_W-1:0]                  chan2_i,
  input  logic [p2oc_pkg::CHAN_W-1:0]                  chan3_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output logic [p2oc_pkg::CHAN_W-1:0]                  cell_value_o,
  output logic [2*COORD_BITS-1:0]                      cell_index_o
);
  import p2oc_pkg::*;

  localparam int DimW = COORD_BITS + 1;
  localparam int IdxW = 2 * COORD_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [1:0]       mode_q;
  logic             negate_q;
  logic [THR_W-1:0] occ_thr_q, free_thr_q;
  logic [CNT_W-1:0] chan_cnt_q;
  logic             alpha_q;
  logic [DimW-1:0]  map_width_q, map_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_TRINARY;
      negate_q     <= 1'b0;
      occ_thr_q    <= OCC_THR_RST;
      free_thr_q   <= FREE_THR_RST;
      chan_cnt_q   <= CHAN_CNT_RST;
      alpha_q      <= 1'b0;
      map_width_q  <= DimW'(1) << COORD_BITS;
      map_height_q <= DimW'(1) << COORD_BITS;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:       mode_q       <= cfg_data_i[1:0];
        REG_NEGATE:     negate_q     <= cfg_data_i[0];
        REG_OCC_THR:    occ_thr_q    <= cfg_data_i[THR_W-1:0];
        REG_FREE_THR:   free_thr_q   <= cfg_data_i[THR_W-1:0];
        REG_CHAN_CNT:   chan_cnt_q   <= cfg_data_i[CNT_W-1:0];
        REG_ALPHA:      alpha_q      <= cfg_data_i[0];
        REG_MAP_WIDTH:  map_width_q  <= cfg_data_i[DimW-1:0];
        REG_MAP_HEIGHT: map_height_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  // Channel count clamped to 1..4; alpha drops out of the average in scale
  // and raw modes only. Mode three behaves as trinary.
  logic [CNT_W-1:0] n_use, avg_n;
  logic             scale_mode, raw_mode;

  always_comb begin
    case (chan_cnt_q)
      3'd0:    n_use = 3'd1;
      3'd1:    n_use = 3'd1;
      3'd2:    n_use = 3'd2;
      3'd3:    n_use = 3'd3;
      3'd4:    n_use = 3'd4;
      default: n_use = 3'd4;
    endcase
    avg_n = n_use;
    if ((mode_q == MODE_SCALE || mode_q == MODE_RAW) && alpha_q && n_use > 3'd1) begin
      avg_n = n_use - 3'd1;
    end
  end

  assign scale_mode = (mode_q == MODE_SCALE);
  assign raw_mode   = (mode_q == MODE_RAW);

  // ---------------------------------------------------------------------
  // Stage 1: capture the pixel
  // ---------------------------------------------------------------------
  logic                           s1_v_q, s1_rdy;
  logic [COORD_BITS-1:0]          s1_col_q, s1_row_q;
  logic [NUM_CH-1:0][CHAN_W-1:0]  s1_ch_q;
  logic                           s2_rdy;

  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_stall_o = !s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_col_q <= column_i;
      s1_row_q <= row_i;
      s1_ch_q  <= {chan3_i, chan2_i, chan1_i, chan0_i};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: channel sum, optional negate, occupancy numerator, flipped row
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0] sum2, den2, a2, b2;
  logic             lastzero2;
  logic [IdxW-1:0]  h2;

  always_comb begin
    sum2 = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      if (CNT_W'(k) < avg_n) begin
        sum2 = sum2 + SUM_W'(s1_ch_q[k]);
      end
    end
    den2      = (SUM_W'(avg_n) << CHAN_W) - SUM_W'(avg_n);
    a2        = negate_q ? (den2 - sum2) : sum2;
    b2        = den2 - a2;
    lastzero2 = (n_use > 3'd1) && (s1_ch_q[2'(n_use - 3'd1)] == '0);
    h2        = IdxW'(map_height_q) - IdxW'(s1_row_q) - IdxW'(1);
  end

  logic                  s2_v_q, s3_rdy;
  logic [CNT_W-1:0]      s2_c_q;
  logic [SUM_W-1:0]      s2_a_q, s2_b_q;
  logic                  s2_lastzero_q;
  logic [COORD_BITS-1:0] s2_col_q;
  logic [IdxW-1:0]       s2_h_q;

  assign s2_rdy = !s2_v_q || s3_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_c_q        <= avg_n;
      s2_a_q        <= a2;
      s2_b_q        <= b2;
      s2_lastzero_q <= lastzero2;
      s2_col_q      <= s1_col_q;
      s2_h_q        <= h2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: threshold products, raw average, row offset product
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]  den3;
  logic [PROD_W-1:0] o_den3, f_den3;
  logic [19:0]       third3;
  logic [CHAN_W-1:0] raw3;
  logic [IdxW-1:0]   prod3;

  always_comb begin
    den3   = (SUM_W'(s2_c_q) << CHAN_W) - SUM_W'(s2_c_q);
    o_den3 = PROD_W'(occ_thr_q) * PROD_W'(den3);
    f_den3 = PROD_W'(free_thr_q) * PROD_W'(den3);
    // Divide by three: 683 / 2048 is exact after the floor for sums this small.
    third3 = 20'(s2_a_q) * 20'd683;
    case (s2_c_q)
      3'd2:    raw3 = CHAN_W'(s2_a_q >> 1);
      3'd3:    raw3 = CHAN_W'(third3 >> 11);
      3'd4:    raw3 = CHAN_W'(s2_a_q >> 2);
      default: raw3 = CHAN_W'(s2_a_q);
    endcase
    prod3 = IdxW'(map_width_q) * s2_h_q;
  end

  logic                  s3_v_q, s4_rdy;
  logic [SUM_W-1:0]      s3_b_q;
  logic [PROD_W-1:0]     s3_o_den_q, s3_f_den_q;
  logic [CHAN_W-1:0]     s3_raw_q;
  logic                  s3_lastzero_q;
  logic [IdxW-1:0]       s3_prod_q;
  logic [COORD_BITS-1:0] s3_col_q;

  assign s3_rdy = !s3_v_q || s4_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      s3_b_q        <= s2_b_q;
      s3_o_den_q    <= o_den3;
      s3_f_den_q    <= f_den3;
      s3_raw_q      <= raw3;
      s3_lastzero_q <= s2_lastzero_q;
      s3_prod_q     <= prod3;
      s3_col_q      <= s2_col_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: classify against both thresholds or pass the raw average, form divider operands
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0] occ4, diff4, dden4;
  logic              gt4, lt4;
  logic [CHAN_W-1:0] fixed4;
  logic              use_quot4;
  logic [IdxW-1:0]   idx4;

  always_comb begin
    occ4      = PROD_W'(s3_b_q) << THR_W;
    gt4       = occ4 > s3_o_den_q;
    lt4       = occ4 < s3_f_den_q;
    diff4     = occ4 - s3_f_den_q;
    dden4     = s3_o_den_q - s3_f_den_q;
    use_quot4 = 1'b0;
    if (raw_mode) begin
      fixed4 = s3_raw_q;
    end else if (gt4) begin
      fixed4 = CELL_OCCUPIED;
    end else if (lt4) begin
      fixed4 = CELL_FREE;
    end else if (!scale_mode || s3_lastzero_q) begin
      fixed4 = CELL_UNKNOWN;
    end else if (occ_thr_q <= free_thr_q) begin
      fixed4 = CELL_FREE;
    end else begin
      fixed4    = CELL_FREE;
      use_quot4 = 1'b1;
    end
    idx4 = s3_prod_q + IdxW'(s3_col_q);
  end

  logic              s4_v_q, s5_rdy;
  logic [PROD_W-1:0] s4_diff_q, s4_dden_q;
  logic [CHAN_W-1:0] s4_fixed_q;
  logic              s4_use_quot_q;
  logic [IdxW-1:0]   s4_idx_q;

  assign s4_rdy = !s4_v_q || s5_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_rdy && s3_v_q) begin
      s4_diff_q     <= diff4;
      s4_dden_q     <= dden4;
      s4_fixed_q    <= fixed4;
      s4_use_quot_q <= use_quot4;
      s4_idx_q      <= idx4;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: scale the numerator by 99 and load the divider beat
  // ---------------------------------------------------------------------
  div_t s5_d, s5_q;
  logic s5_v_q;
  logic [IdxW-1:0] s5_idx_q;

  always_comb begin
    s5_d.rem      = NUM_W'(s4_diff_q) * NUM_W'(SCALE_TOP);
    s5_d.den      = s4_dden_q;
    s5_d.quot     = '0;
    s5_d.fixed    = s4_fixed_q;
    s5_d.use_quot = s4_use_quot_q;
  end

  logic [QUOT_W:0]           d_valid, d_ready;
  div_t                      d_data [QUOT_W+1];
  logic [IdxW-1:0]           d_idx  [QUOT_W+1];

  assign s5_rdy = !s5_v_q || d_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (s5_rdy) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_rdy && s4_v_q) begin
      s5_q     <= s5_d;
      s5_idx_q <= s4_idx_q;
    end
  end

  // ---------------------------------------------------------------------
  // Divider: one quotient bit per stage, most significant first
  // ---------------------------------------------------------------------
  assign d_valid[0] = s5_v_q;
  assign d_data[0]  = s5_q;
  assign d_idx[0]   = s5_idx_q;

  for (genvar g = 0; g < QUOT_W; g++) begin : g_div
    p2oc_div_stage #(
      .Shift (QUOT_W - 1 - g),
      .IdxW  (IdxW)
    ) u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (d_valid[g]),
      .up_ready_o (d_ready[g]),
      .up_data_i  (d_data[g]),
      .up_idx_i   (d_idx[g]),
      .dn_valid_o (d_valid[g+1]),
      .dn_ready_i (d_ready[g+1]),
      .dn_data_o  (d_data[g+1]),
      .dn_idx_o   (d_idx[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Output register: pick the quotient or the fixed code, hold while stalled
  // ---------------------------------------------------------------------
  logic              out_v_q, out_rdy;
  logic [CHAN_W-1:0] out_value_q;
  logic [IdxW-1:0]   out_idx_q;

  assign out_rdy          = !out_v_q || !out_stall_i;
  assign d_ready[QUOT_W]  = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= d_valid[QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && d_valid[QUOT_W]) begin
      out_value_q <= d_data[QUOT_W].use_quot ? CHAN_W'(d_data[QUOT_W].quot)
                                             : d_data[QUOT_W].fixed;
      out_idx_q   <= d_idx[QUOT_W];
    end
  end

  assign out_valid_o  = out_v_q;
  assign cell_value_o = out_value_q;
  assign cell_index_o = out_idx_q;

endmodule

[sv/p2oc_div_stage.sv]
// One restoring-division step with its own pipeline register and handshake.
// Depends on p2oc_pkg for the divider beat type.
module p2oc_div_stage #(
  parameter int Shift = 0,
  parameter int IdxW  = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              up_valid_i,
  output logic              up_ready_o,
  input  p2oc_pkg::div_t    up_data_i,
  input  logic [IdxW-1:0]   up_idx_i,
  output logic              dn_valid_o,
  input  logic              dn_ready_i,
  output p2oc_pkg::div_t    dn_data_o,
  output logic [IdxW-1:0]   dn_idx_o
);
  import p2oc_pkg::*;

  logic            valid_q;
  div_t            data_q, data_d;
  logic [IdxW-1:0] idx_q;
  logic [NUM_W-1:0] trial;

  assign up_ready_o = !valid_q || dn_ready_i;

  // Subtract the shifted divisor when it fits and set this quotient bit.
  always_comb begin
    trial  = NUM_W'(up_data_i.den) << Shift;
    data_d = up_data_i;
    if (up_data_i.rem >= trial) begin
      data_d.rem         = up_data_i.rem - trial;
      data_d.quot[Shift] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
      idx_q  <= up_idx_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;
  assign dn_idx_o   = idx_q;

endmodule

[tb/pixel_to_occupancy_cell_test.sv]
// Self-checking bench for pixel_to_occupancy_cell: directed corner pixels and
// register settings, then random settings and pixel streams under backpressure.
// Depends on p2oc_pkg and the pixel_to_occupancy_cell RTL.
module pixel_to_occupancy_cell_test;
  import p2oc_pkg::*;

  localparam int CB         = COORD_BITS_DEF;
  localparam int CFG_W      = (CB + 1 > THR_W) ? CB + 1 : THR_W;
  localparam int LATENCY    = 13;
  localparam int QUIET_MAX  = 2000;   // cycles without any beat before giving up
  localparam int LONG_HOLD  = 400;    // receiver hold-off that backs up the pipe
  localparam int RANDOM_PIX = 1850;
  localparam int CALM_AFTER = 1500;   // random pixels sent before gaps stop

  // Code 3 is not a named mode; the block must handle it as trinary.
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic [12:0] MAP_DIM_RST = 13'd4096;
  localparam logic [12:0] MAP_DIM_TOP = 13'd8191;
  localparam logic [15:0] THR_TOP     = 16'hFFFF;

  typedef struct {
    logic [CB-1:0]     column;
    logic [CB-1:0]     row;
    logic [CHAN_W-1:0] chan [NUM_CH];
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic [2*CB-1:0]   index;
  } grid_out_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic             negate;
    logic [THR_W-1:0] occ_thr;
    logic [THR_W-1:0] free_thr;
    logic [CNT_W-1:0] chan_cnt;
    logic             alpha;
    logic [12:0]      width;
    logic [12:0]      height;
  } map_regs_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [2:0]         cfg_idx    = '0;
  logic [CFG_W-1:0]   cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [CB-1:0]      column     = '0;
  logic [CB-1:0]      row        = '0;
  logic [CHAN_W-1:0]  chan0      = '0;
  logic [CHAN_W-1:0]  chan1      = '0;
  logic [CHAN_W-1:0]  chan2      = '0;
  logic [CHAN_W-1:0]  chan3      = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [CHAN_W-1:0]  cell_value;
  logic [2*CB-1:0]    cell_index;

  // Shadow of the block's registers, updated as each write is issued.
  map_regs_t regs = '{mode: MODE_TRINARY, negate: 1'b0, occ_thr: OCC_THR_RST,
                      free_thr: FREE_THR_RST, chan_cnt: CHAN_CNT_RST, alpha: 1'b0,
                      width: MAP_DIM_RST, height: MAP_DIM_RST};

  pixel_t    pixels_pending [$];   // pixels not yet offered to the block
  grid_out_t cells_due      [$];   // predicted cells, oldest first

  logic in_taken   = 1'b0;         // the beat on the input was accepted last edge
  bit   send_gaps  = 1'b1;
  bit   recv_gaps  = 1'b1;
  bit   hold_req   = 1'b0;         // toggle to ask the receiver for a long hold
  bit   hold_ack   = 1'b0;
  int   send_gap   = 0;
  int   recv_gap   = 0;
  int   hold_left  = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;

  pixel_to_occupancy_cell u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .column_i     (column),
    .row_i        (row),
    .chan0_i      (chan0),
    .chan1_i      (chan1),
    .chan2_i      (chan2),
    .chan3_i      (chan3),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .cell_value_o (cell_value),
    .cell_index_o (cell_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the grid cell for one pixel under the current register shadow.
  // Every comparison is exact: the average S/c is scaled by 255c and the
  // Q0.16 thresholds by 2^16, so no fraction is ever rounded.
  function automatic grid_out_t predict_cell(pixel_t p);
    grid_out_t        r;
    int unsigned      n, navg, sum, k;
    longint unsigned  a, b, c, den, occ_q, o, f, w, h, py, px, idx;
    n = regs.chan_cnt;
    if (n == 0) n = 1;
    if (n > NUM_CH) n = NUM_CH;
    // Alpha drops out of the average only outside trinary-like modes and
    // only when there is more than one channel.
    navg = n;
    if ((regs.mode == MODE_SCALE || regs.mode == MODE_RAW) && regs.alpha && n > 1)
      navg = n - 1;
    sum = 0;
    for (k = 0; k < navg; k++) sum += p.chan[k];
    c = navg;
    a = sum;
    if (regs.negate) a = CHAN_FULL * c - a;
    if (regs.mode == MODE_RAW) begin
      r.value = a / c;
    end else begin
      b     = CHAN_FULL * c - a;
      occ_q = b << THR_W;
      den   = CHAN_FULL * c;
      o     = regs.occ_thr;
      f     = regs.free_thr;
      if (occ_q > o * den) begin
        r.value = CELL_OCCUPIED;
      end else if (occ_q < f * den) begin
        r.value = CELL_FREE;
      end else if (regs.mode != MODE_SCALE || (regs.chan_cnt > 1 && p.chan[n-1] == 0)) begin
        r.value = CELL_UNKNOWN;
      end else if (o <= f) begin
        r.value = CELL_FREE;
      end else begin
        r.value = (SCALE_TOP * (occ_q - f * den)) / ((o - f) * den);
      end
    end
    // Row flip wraps freely; only the low index bits survive.
    w   = regs.width;
    h   = regs.height;
    py  = p.row;
    px  = p.column;
    idx = w * (h - 1 - py) + px;
    r.index = idx[2*CB-1:0];
    return r;
  endfunction

  // Scoreboard: predict on every input beat, check every output beat.
  always @(posedge clk) begin : scoreboard
    pixel_t    p;
    grid_out_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      p.column  = column;
      p.row     = row;
      p.chan[0] = chan0;
      p.chan[1] = chan1;
      p.chan[2] = chan2;
      p.chan[3] = chan3;
      cells_due.push_back(predict_cell(p));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual value %0d index %0d",
                 $time, cell_value, cell_index);
        mismatches++;
      end else begin
        want = cells_due.pop_front();
        if (cell_value !== want.value) begin
          $display("%0t: cell_value expected %0d actual %0d", $time, want.value, cell_value);
          mismatches++;
        end
        if (cell_index !== want.index) begin
          $display("%0t: cell_index expected %0d actual %0d", $time, want.index, cell_index);
          mismatches++;
        end
      end
    end
  end

  // Sender: hold a stalled beat, otherwise advance to the next pixel or idle.
  always @(negedge clk) begin : sender
    pixel_t p;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (send_gap == 0 && send_gaps && $urandom_range(0, 9) == 0)
        send_gap = $urandom_range(1, 19);
      if (send_gap > 0 || pixels_pending.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        p = pixels_pending.pop_front();
        column   <= p.column;
        row      <= p.row;
        chan0    <= p.chan[0];
        chan1    <= p.chan[1];
        chan2    <= p.chan[2];
        chan3    <= p.chan[3];
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk) begin : receiver
    logic hold;
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      hold = 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      hold = 1'b1;
    end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 18);
      hold = 1'b1;
    end else begin
      hold = 1'b0;
    end
    out_stall <= hold;
  end

  // Watchdog: any beat or register write counts as progress.
  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QUIET_MAX) begin
      $display("pixel_to_occupancy_cell_test NOT OK");
      $finish;
    end
  end

  task automatic set_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    case (idx)
      REG_MODE:       regs.mode     = v[1:0];
      REG_NEGATE:     regs.negate   = v[0];
      REG_OCC_THR:    regs.occ_thr  = v[THR_W-1:0];
      REG_FREE_THR:   regs.free_thr = v[THR_W-1:0];
      REG_CHAN_CNT:   regs.chan_cnt = v[CNT_W-1:0];
      REG_ALPHA:      regs.alpha    = v[0];
      REG_MAP_WIDTH:  regs.width    = v[12:0];
      REG_MAP_HEIGHT: regs.height   = v[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(input logic [1:0] md, input logic ng,
                           input logic [THR_W-1:0] ot, input logic [THR_W-1:0] ft,
                           input logic [CNT_W-1:0] cc, input logic al,
                           input logic [12:0] w, input logic [12:0] h);
    set_reg(REG_MODE,       CFG_W'(md));
    set_reg(REG_NEGATE,     CFG_W'(ng));
    set_reg(REG_OCC_THR,    CFG_W'(ot));
    set_reg(REG_FREE_THR,   CFG_W'(ft));
    set_reg(REG_CHAN_CNT,   CFG_W'(cc));
    set_reg(REG_ALPHA,      CFG_W'(al));
    set_reg(REG_MAP_WIDTH,  CFG_W'(w));
    set_reg(REG_MAP_HEIGHT, CFG_W'(h));
  endtask

  task automatic put_pixel(input int col, input int rw, input int c0, input int c1,
                           input int c2, input int c3);
    pixel_t p;
    p.column  = col;
    p.row     = rw;
    p.chan[0] = c0;
    p.chan[1] = c1;
    p.chan[2] = c2;
    p.chan[3] = c3;
    pixels_pending.push_back(p);
  endtask

  // Wait until every pixel is sent and every predicted cell has come back.
  // Let the sender's falling-edge updates settle before looking.
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (pixels_pending.size() != 0 || in_valid || cells_due.size() != 0);
  endtask

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return 13'd1;
      1:       return MAP_DIM_RST;
      2:       return MAP_DIM_TOP;
      3:       return 13'd0;
      4:       return $urandom_range(0, MAP_DIM_TOP);
      default: return $urandom_range(1, MAP_DIM_RST);
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CHAN_FULL;
      default: return $urandom_range(0, CHAN_FULL);
    endcase
  endfunction

  task automatic random_regs();
    logic [1:0]       md;
    logic [THR_W-1:0] ot, ft, tmp;
    logic [CNT_W-1:0] cc;
    int               r;
    r  = $urandom_range(0, 9);
    md = (r < 3) ? MODE_TRINARY : (r < 7) ? MODE_SCALE : (r < 9) ? MODE_RAW : MODE_SPARE;
    ot = $urandom_range(0, THR_TOP);
    ft = $urandom_range(0, THR_TOP);
    case ($urandom_range(0, 7))
      0: begin ot = THR_TOP; ft = '0; end
      1: begin ot = '0; ft = THR_TOP; end
      2: ft = ot;
      3: begin ot = '0; ft = '0; end
      4: ;                                   // keep any order, inverted too
      default: if (ot < ft) begin tmp = ot; ot = ft; ft = tmp; end
    endcase
    r  = $urandom_range(0, 9);
    cc = (r < 8) ? CNT_W'(1 + r % NUM_CH) : (r == 8) ? '0 : CNT_W'($urandom_range(5, 7));
    load_regs(md, $urandom_range(0, 1), ot, ft, cc, $urandom_range(0, 1),
              pick_dim(), pick_dim());
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     k;
    p.column = $urandom_range(0, (1 << CB) - 1);
    // Mostly rows inside the map, the rest anywhere in the field.
    if (regs.height >= 1 && regs.height <= (1 << CB) && $urandom_range(0, 3) != 0)
      p.row = $urandom_range(0, regs.height - 1);
    else
      p.row = $urandom_range(0, (1 << CB) - 1);
    for (k = 0; k < NUM_CH; k++) p.chan[k] = pick_byte();
    return p;
  endfunction

  initial begin : stimulus
    int sent;
    int phase;
    int len;
    int k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: all-zero and all-ones pixels, then an ordinary one.
    put_pixel(0, 0, 0, 0, 0, 0);
    put_pixel(4095, 4095, 255, 255, 255, 255);
    put_pixel(5, 100, 128, 7, 9, 1);
    drain();

    // Scale mode with equal thresholds; alpha drops the third channel. The
    // first pixel sits exactly on the threshold, the second has a zero last
    // channel and must read unknown.
    load_regs(MODE_SCALE, 1'b0, 16'd32768, 16'd32768, 3'd3, 1'b1, 13'd640, 13'd480);
    put_pixel(10, 20, 255, 0, 9, 0);
    put_pixel(1, 479, 255, 0, 0, 0);
    put_pixel(639, 0, 0, 0, 0, 7);
    put_pixel(3, 3, 255, 255, 255, 255);
    drain();

    // Full threshold span, negated, alpha flag with a single channel (ignored).
    load_regs(MODE_SCALE, 1'b1, THR_TOP, 16'd0, 3'd1, 1'b1, 13'd1, 13'd1);
    put_pixel(0, 0, 0, 0, 0, 0);
    put_pixel(0, 0, 255, 0, 0, 0);
    put_pixel(7, 0, 128, 1, 2, 3);
    put_pixel(4095, 0, 200, 0, 0, 0);
    drain();

    // Spare mode code and a zero channel count; zero map size wraps the index.
    load_regs(MODE_SPARE, 1'b0, OCC_THR_RST, FREE_THR_RST, 3'd0, 1'b1, 13'd0, 13'd0);
    put_pixel(4095, 4095, 100, 255, 255, 0);
    put_pixel(0, 0, 30, 0, 0, 0);
    drain();

    // Raw mode, channel count clamped from seven, largest map size.
    load_regs(MODE_RAW, 1'b1, 16'd0, THR_TOP, 3'd7, 1'b1, MAP_DIM_TOP, MAP_DIM_TOP);
    put_pixel(4095, 0, 255, 255, 255, 0);
    put_pixel(0, 4095, 1, 2, 3, 4);
    drain();

    // Trinary keeps alpha in the average.
    load_regs(MODE_TRINARY, 1'b0, 16'd40000, 16'd20000, 3'd4, 1'b1, 13'd100, 13'd50);
    put_pixel(99, 49, 255, 255, 255, 0);
    put_pixel(0, 0, 128, 128, 128, 128);
    drain();

    // Random phases: new settings, a burst of pixels, then wait for the pipe
    // to empty before the registers may change again.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PIX) begin
      random_regs();
      len = (phase == 2) ? 120 : $urandom_range(20, 90);
      if (sent >= CALM_AFTER) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end else begin
        send_gaps = $urandom_range(0, 3) != 0;
        recv_gaps = $urandom_range(0, 3) != 0;
      end
      // Stall the output for a long stretch while pixels keep coming, so the
      // pipeline fills and pushes back on the input.
      if (phase == 2) hold_req = ~hold_req;
      for (k = 0; k < len; k++) pixels_pending.push_back(random_pixel());
      sent += len;
      phase++;
      drain();
    end

    repeat (LATENCY + 10) @(negedge clk);
    if (mismatches == 0 && cells_due.size() == 0)
      $display("pixel_to_occupancy_cell_test OK");
    else
      $display("pixel_to_occupancy_cell_test NOT OK");
    $finish;
  end

endmodule
